@@ rtl/escaped_frame_receiver_assert.svh @@
`ifndef ESCAPED_FRAME_RECEIVER_ASSERT_SVH
`define ESCAPED_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while reset is low
`define EFR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define EFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/efr_pkg.sv @@
`default_nettype none

package efr_pkg;

	localparam int ADDR_W = 8;

	localparam logic [7:0] START_RST  = 8'hAA;
	localparam logic [7:0] END_RST    = 8'h55;
	localparam logic [7:0] ESCAPE_RST = 8'h7D;

	localparam logic [7:0] ESC_CODE_START  = 8'h01;
	localparam logic [7:0] ESC_CODE_END    = 8'h02;
	localparam logic [7:0] ESC_CODE_ESCAPE = 8'h03;

	localparam logic [1:0] REG_START  = 2'd0;
	localparam logic [1:0] REG_END    = 2'd1;
	localparam logic [1:0] REG_ESCAPE = 2'd2;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_EMPTY_OK = 2'd1,
		KIND_NO_BYTES = 2'd2,
		KIND_BAD_SUM  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RECV,
		ST_ESC,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] end_byte;
		logic [7:0] escape_byte;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage

`default_nettype wire

@@ rtl/escaped_frame_receiver.sv @@
// channel   signals                          dir   payload
// rx        rx_valid / rx_ready              in    rx_byte
// res       res_valid / res_ready            out   kind, data, last
// cfg       cfg_wen, cfg_index, cfg_data     in    start, end, escape byte
//
// rx_ready is low while a result beat waits with res_ready low, so a byte gets in only in
// the cycle the waiting beat leaves.
// a good frame end drains count-1 payload beats: the first read issues the cycle after
// the end byte, then one beat per cycle while res_ready is high; rx_ready stays low
// during the drain. reset is asynchronous and needs no clearing pass: the frame store
// is never read past what the open frame wrote. res_ready low stalls the drain in place.
`default_nettype none

module escaped_frame_receiver import efr_pkg::*; #(
	parameter int FRAME_DEPTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wen,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       rx_valid,
	output logic            rx_ready,
	input  wire logic [7:0] rx_byte,
	output logic            res_valid,
	input  wire logic       res_ready,
	output logic [1:0]      kind,
	output logic [7:0]      data,
	output logic            last
);

	cfg_t       cfg_q;
	mem_req_t   mem_req;
	logic [7:0] rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte  <= START_RST;
			cfg_q.end_byte    <= END_RST;
			cfg_q.escape_byte <= ESCAPE_RST;
		end else if (cfg_wen) begin
			priority case (cfg_index)
				REG_START:  cfg_q.start_byte  <= cfg_data;
				REG_END:    cfg_q.end_byte    <= cfg_data;
				REG_ESCAPE: cfg_q.escape_byte <= cfg_data;
				default:    ;
			endcase
		end
	end

	efr_ctrl #(
		.FRAME_DEPTH(FRAME_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.rx_valid  (rx_valid),
		.rx_ready  (rx_ready),
		.rx_byte   (rx_byte),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.kind      (kind),
		.data      (data),
		.last      (last),
		.mem_req   (mem_req),
		.rd_data   (rd_data)
	);

	efr_store #(
		.DEPTH(FRAME_DEPTH)
	) u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire

@@ rtl/efr_store.sv @@
`default_nettype none

module efr_store import efr_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  wire logic       clk,
	input  mem_req_t        req,
	output logic [7:0]      rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data_q <= mem[req.raddr[AW-1:0]];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/efr_ctrl.sv @@
`default_nettype none

module efr_ctrl import efr_pkg::*; #(
	parameter int FRAME_DEPTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  cfg_t            cfg,
	input  wire logic       rx_valid,
	output logic            rx_ready,
	input  wire logic [7:0] rx_byte,
	output logic            res_valid,
	input  wire logic       res_ready,
	output logic [1:0]      kind,
	output logic [7:0]      data,
	output logic            last,
	output mem_req_t        mem_req,
	input  wire logic [7:0] rd_data
);

	localparam int CW = $clog2(FRAME_DEPTH + 1);

	state_t        state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [7:0]    xor_q, xor_d;
	logic [CW-1:0] rd_ptr_q, rd_ptr_d;
	logic          rd_valid_s1, rd_valid_d;
	logic          rd_last_s1, rd_last_d;

	logic          res_valid_q;
	kind_t         kind_q;
	logic [7:0]    data_q;
	logic          last_q;

	logic          adv, take;
	logic          load, load_last;
	kind_t         load_kind;
	logic [7:0]    load_data;
	logic          store_en;
	logic [7:0]    store_val;
	logic [CW-1:0] npay;

	assign adv      = !res_valid_q || res_ready;
	assign rx_ready = (state_q != ST_DRAIN) && adv;
	assign take     = rx_valid && rx_ready;
	assign npay     = count_q - CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			xor_q       <= '0;
			rd_ptr_q    <= '0;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			count_q     <= count_d;
			xor_q       <= xor_d;
			rd_ptr_q    <= rd_ptr_d;
			rd_valid_s1 <= rd_valid_d;
			rd_last_s1  <= rd_last_d;
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= load_kind;
			data_q <= load_data;
			last_q <= load_last;
		end
	end

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		xor_d      = xor_q;
		rd_ptr_d   = rd_ptr_q;
		rd_valid_d = rd_valid_s1;
		rd_last_d  = rd_last_s1;
		mem_req    = '0;
		load       = 1'b0;
		load_kind  = KIND_PAYLOAD;
		load_data  = '0;
		load_last  = 1'b0;
		store_en   = 1'b0;
		store_val  = rx_byte;

		unique case (state_q)
			ST_IDLE: begin
				if (take && rx_byte == cfg.start_byte) begin
					state_d = ST_RECV;
					count_d = '0;
					xor_d   = '0;
				end
			end
			ST_RECV: begin
				if (take) begin
					// escape wins over end when both registers match
					priority if (rx_byte == cfg.escape_byte) begin
						state_d = ST_ESC;
					end else if (rx_byte == cfg.end_byte) begin
						state_d   = ST_IDLE;
						load      = 1'b1;
						load_last = 1'b1;
						priority if (count_q == '0) begin
							load_kind = KIND_NO_BYTES;
						end else if (xor_q != '0) begin
							load_kind = KIND_BAD_SUM;
						end else if (count_q == CW'(1)) begin
							load_kind = KIND_EMPTY_OK;
						end else begin
							load       = 1'b0;
							state_d    = ST_DRAIN;
							rd_ptr_d   = '0;
							rd_valid_d = 1'b0;
						end
					end else begin
						store_en = 1'b1;
					end
				end
			end
			ST_ESC: begin
				if (take) begin
					priority if (rx_byte == ESC_CODE_START) begin
						store_en  = 1'b1;
						store_val = cfg.start_byte;
					end else if (rx_byte == ESC_CODE_END) begin
						store_en  = 1'b1;
						store_val = cfg.end_byte;
					end else if (rx_byte == ESC_CODE_ESCAPE) begin
						store_en  = 1'b1;
						store_val = cfg.escape_byte;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DRAIN: begin
				// stage 1 holds the read beat until the output register frees up
				if (rd_valid_s1 && adv) begin
					load       = 1'b1;
					load_kind  = KIND_PAYLOAD;
					load_data  = rd_data;
					load_last  = rd_last_s1;
					rd_valid_d = 1'b0;
				end
				if (!rd_valid_s1 || adv) begin
					if (rd_ptr_q != npay) begin
						mem_req.re    = 1'b1;
						mem_req.raddr = ADDR_W'(rd_ptr_q);
						rd_ptr_d      = rd_ptr_q + CW'(1);
						rd_valid_d    = 1'b1;
						rd_last_d     = (rd_ptr_q + CW'(1) == npay);
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
		endcase

		if (store_en) begin
			if (count_q != CW'(FRAME_DEPTH)) begin
				mem_req.we    = 1'b1;
				mem_req.waddr = ADDR_W'(count_q);
				mem_req.wdata = store_val;
				count_d       = count_q + CW'(1);
				xor_d         = xor_q ^ store_val;
				state_d       = ST_RECV;
			end else begin
				// overflow drops the frame
				state_d = ST_IDLE;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign kind      = kind_q;
	assign data      = data_q;
	assign last      = last_q;

endmodule

`default_nettype wire

@@ rtl/efr_chk.sv @@
`default_nettype none

`include "escaped_frame_receiver_assert.svh"

module efr_chk import efr_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       rx_ready,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [1:0] kind,
	input wire logic [7:0] data,
	input wire logic       last
);

	// a stalled result beat holds
	`EFR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable({kind, data, last}), "result beat changed while stalled")

	// error and empty-frame results stand alone
	`EFR_ASSERT_NOW(a_single_last, res_valid && kind != KIND_PAYLOAD, last, "single result without last")

	`EFR_ASSERT_NOW(a_single_zero, res_valid && kind != KIND_PAYLOAD, data == 8'h00, "single result with nonzero data")

	// mid-frame payload taken: the next payload beat follows at once
	`EFR_ASSERT_NEXT(a_drain_runs, res_valid && res_ready && kind == KIND_PAYLOAD && !last, res_valid && kind == KIND_PAYLOAD, "drain paused with a payload beat still due")

	// rx stays blocked while the drain has beats left
	`EFR_ASSERT_NOW(a_drain_blocks, res_valid && kind == KIND_PAYLOAD && !last, !rx_ready, "rx opened before the drain finished")

endmodule

bind escaped_frame_receiver efr_chk u_chk (.*);

`default_nettype wire
